### rtl/core/htfd_pkg.sv
`default_nettype none

package htfd_pkg;

    // CRC-8, MSB first, no final xor
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // byte positions within a six-byte reply
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // fixed-point conversion constants
    localparam logic [14:0] T_SCALE = 15'd17500;
    localparam logic [13:0] H_SCALE = 14'd10000;
    localparam logic [15:0] T_BASE  = 16'd4500;

    // register map
    localparam int         PADDR_W         = 3;
    localparam logic [0:0] REG_TEMP_OFFSET = 1'b0;

    // one complete, checked reply
    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] humid_word;
        logic        temp_ok;
        logic        humid_ok;
    } t_frame;

    // one byte through the CRC, bit by bit
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/htfd_in_if.sv
`default_nettype none

interface htfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

`default_nettype wire

### rtl/core/htfd_out_if.sv
`default_nettype none

interface htfd_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temperature_centi;
    logic        [13:0] humidity_centi;
    logic               temp_crc_ok;
    logic               humid_crc_ok;
    logic               reading_valid;

    modport source (output valid, output temperature_centi, output humidity_centi,
                    output temp_crc_ok, output humid_crc_ok, output reading_valid,
                    input ready);
    modport sink   (input valid, input temperature_centi, input humidity_centi,
                    input temp_crc_ok, input humid_crc_ok, input reading_valid,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/humidity_temp_frame_decoder.sv
// Sensor reply decoder.
// Input channel i_in carries one word per reply byte: temperature MSB, LSB,
// CRC, humidity MSB, LSB, CRC. frame_start on a word forces it to be taken
// as the first byte of a reply. Each 16-bit value is checked with CRC-8
// (poly 0x31, init 0xFF).
// Output channel o_out carries one word per reply: temperature in 0.01 C
// (offset register added), humidity in 0.01 %RH, and the CRC flags. Values
// are given even when a CRC fails; reading_valid is then low.
// APB register 0 (byte address 0): temp_offset_centi, 12-bit signed.
// The result is registered: the frame register loads at the edge that accepts
// the last CRC byte, and the conversion/result register loads from it once
// the output side can take it.
// Throughput: one byte per cycle while i_in.ready is high; the CRC of a byte is a
// combinational xor network and the conversion multipliers sit in their own stage.
// Reset clears position, CRC, offset and both valid flags.
// When the receiver stalls, the result is held, one more finished reply can
// wait in the frame register, and after that i_in.ready drops.

`default_nettype none

module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    htfd_in_if.sink                 i_in,
    htfd_out_if.source              o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output      logic [31:0]        prdata,
    output      logic               pready
);

    logic [11:0] r_temp_offset;
    logic        cfg_write;

    logic        in_accept;
    logic        frame_done;
    t_frame      frame;

    logic        r_s1_valid;
    t_frame      r_s1_frame;
    logic        s1_ready;

    logic               r_out_valid;
    logic signed [14:0] r_out_temp;
    logic        [13:0] r_out_humid;
    logic               r_out_temp_ok;
    logic               r_out_humid_ok;
    logic               out_load;

    logic [30:0] t_prod;
    logic [29:0] h_prod;
    logic [15:0] n_temp;

    // config register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TEMP_OFFSET);
    assign prdata    = (paddr[2] == REG_TEMP_OFFSET) ?
                       {{20{r_temp_offset[11]}}, r_temp_offset} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_offset <= '0;
        end else if (cfg_write) begin
            r_temp_offset <= pwdata[11:0];
        end
    end

    // handshake
    assign out_load   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign s1_ready   = !r_s1_valid || out_load;
    assign i_in.ready = s1_ready;
    assign in_accept  = i_in.valid && s1_ready;

    htfd_framer u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_rx_byte     (i_in.rx_byte),
        .i_frame_start (i_in.frame_start),
        .o_done        (frame_done),
        .o_frame       (frame)
    );

    // frame register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (frame_done) begin
            r_s1_valid <= 1'b1;
        end else if (out_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            r_s1_frame <= frame;
        end
    end

    // fixed-point conversion
    always_comb begin
        t_prod = 31'(r_s1_frame.temp_word) * 31'(T_SCALE);
        h_prod = 30'(r_s1_frame.humid_word) * 30'(H_SCALE);
        n_temp = {1'b0, t_prod[30:16]} - T_BASE + {{4{r_temp_offset[11]}}, r_temp_offset};
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_temp     <= $signed(n_temp[14:0]);
            r_out_humid    <= h_prod[29:16];
            r_out_temp_ok  <= r_s1_frame.temp_ok;
            r_out_humid_ok <= r_s1_frame.humid_ok;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.temperature_centi = r_out_temp;
    assign o_out.humidity_centi    = r_out_humid;
    assign o_out.temp_crc_ok       = r_out_temp_ok;
    assign o_out.humid_crc_ok      = r_out_humid_ok;
    assign o_out.reading_valid     = r_out_temp_ok && r_out_humid_ok;

    // a result only appears after a frame was waiting
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result without a pending frame");

    // input only blocked while a frame is waiting
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_valid && r_out_valid && !o_out.ready))
        else $error("input stalled without cause");

    // humidity stays below full scale
    a_humid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_out.humidity_centi <= 14'd9999))
        else $error("humidity out of range");

    // temperature within the reachable span, offset included
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_out.temperature_centi >= -15'sd6548 &&
                         o_out.temperature_centi <= 15'sd15046))
        else $error("temperature out of range");

    // a finished frame never overwrites one that cannot move on
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_done |-> (!r_s1_valid || out_load))
        else $error("frame register overrun");

endmodule

`default_nettype wire

### rtl/core/htfd_framer.sv
`default_nettype none

module htfd_framer
    import htfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_frame_start,
    output      logic       o_done,
    output      t_frame     o_frame
);

    logic [2:0]  r_pos,  n_pos;
    logic [7:0]  r_crc,  n_crc;
    logic [15:0] r_temp_word,  n_temp_word;
    logic [15:0] r_humid_word, n_humid_word;
    logic        r_temp_ok,    n_temp_ok;

    logic [2:0] pos_eff;
    logic [7:0] crc_eff;
    logic [7:0] crc_next;
    logic       crc_match;

    // frame start restarts position and CRC; stray positions act as the first byte
    always_comb begin
        pos_eff   = i_frame_start ? POS_T_HI : r_pos;
        crc_eff   = i_frame_start ? CRC_INIT : r_crc;
        if (pos_eff > POS_H_CRC) begin
            pos_eff = POS_T_HI;
        end
        crc_next  = crc8_byte(crc_eff, i_rx_byte);
        crc_match = (crc_eff == i_rx_byte);
    end

    // per-byte state update
    always_comb begin
        n_pos        = r_pos;
        n_crc        = r_crc;
        n_temp_word  = r_temp_word;
        n_humid_word = r_humid_word;
        n_temp_ok    = r_temp_ok;
        o_done       = 1'b0;
        if (i_accept) begin
            case (pos_eff)
                POS_T_HI: begin
                    n_crc       = crc_next;
                    n_temp_word = {i_rx_byte, r_temp_word[7:0]};
                    n_pos       = POS_T_LO;
                end
                POS_T_LO: begin
                    n_crc       = crc_next;
                    n_temp_word = {r_temp_word[15:8], i_rx_byte};
                    n_pos       = POS_T_CRC;
                end
                POS_T_CRC: begin
                    n_temp_ok = crc_match;
                    n_crc     = CRC_INIT;
                    n_pos     = POS_H_HI;
                end
                POS_H_HI: begin
                    n_crc        = crc_next;
                    n_humid_word = {i_rx_byte, r_humid_word[7:0]};
                    n_pos        = POS_H_LO;
                end
                POS_H_LO: begin
                    n_crc        = crc_next;
                    n_humid_word = {r_humid_word[15:8], i_rx_byte};
                    n_pos        = POS_H_CRC;
                end
                default: begin
                    // humidity CRC byte: frame complete
                    o_done = 1'b1;
                    n_crc  = CRC_INIT;
                    n_pos  = POS_T_HI;
                end
            endcase
        end
    end

    // frame contents as seen by the humidity CRC byte
    always_comb begin
        o_frame.temp_word  = r_temp_word;
        o_frame.humid_word = r_humid_word;
        o_frame.temp_ok    = r_temp_ok;
        o_frame.humid_ok   = crc_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_T_HI;
            r_crc        <= CRC_INIT;
            r_temp_word  <= '0;
            r_humid_word <= '0;
            r_temp_ok    <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_crc        <= n_crc;
            r_temp_word  <= n_temp_word;
            r_humid_word <= n_humid_word;
            r_temp_ok    <= n_temp_ok;
        end
    end

endmodule

`default_nettype wire

### tb/htfd_tb_pkg.sv
package htfd_tb_pkg;
    import htfd_pkg::*;

    // conversion factors, hundredths
    localparam int TEMP_SCALE  = 17500;
    localparam int HUMID_SCALE = 10000;
    localparam int TEMP_BASE   = 4500;

    // one decoded reading as seen on the output channel
    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic        [13:0] humidity_centi;
        logic               temp_crc_ok;
        logic               humid_crc_ok;
        logic               reading_valid;
    } t_reading;

    // CRC-8 over one byte, feedback form, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[7] ^ data[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    // Tracks the reply decoder state and holds the readings still owed
    class reading_scoreboard;
        logic        [2:0]  position;
        logic        [7:0]  crc_acc;
        logic        [15:0] t_word;
        logic        [15:0] h_word;
        logic               t_ok;
        logic signed [11:0] offset;
        t_reading           pending[$];
        int                 errors;

        function new();
            position = POS_T_HI;
            crc_acc  = CRC_INIT;
            t_word   = '0;
            h_word   = '0;
            t_ok     = 1'b0;
            offset   = '0;
            errors   = 0;
        endfunction

        function void set_offset(input logic [11:0] value);
            offset = value;
        endfunction

        // one accepted input word
        function void take_byte(input logic [7:0] b, input logic fs);
            logic [2:0] p;
            logic       h_ok;
            int         t;
            int         h;
            t_reading   r;
            if (fs) begin
                position = POS_T_HI;
                crc_acc  = CRC_INIT;
            end
            // positions past the last one fall back to the first
            p = (position > POS_H_CRC) ? POS_T_HI : position;
            case (p)
                POS_T_CRC: begin
                    t_ok     = (crc_acc == b);
                    crc_acc  = CRC_INIT;
                    position = POS_H_HI;
                end
                POS_H_CRC: begin
                    h_ok = (crc_acc == b);
                    t = ((TEMP_SCALE * int'(t_word)) >> 16) - TEMP_BASE + int'(offset);
                    h = (HUMID_SCALE * int'(h_word)) >> 16;
                    r.temperature_centi = t[14:0];
                    r.humidity_centi    = h[13:0];
                    r.temp_crc_ok       = t_ok;
                    r.humid_crc_ok      = h_ok;
                    r.reading_valid     = t_ok & h_ok;
                    pending.push_back(r);
                    crc_acc  = CRC_INIT;
                    position = POS_T_HI;
                end
                default: begin
                    crc_acc = crc8_step(crc_acc, b);
                    case (p)
                        POS_T_HI: t_word[15:8] = b;
                        POS_T_LO: t_word[7:0]  = b;
                        POS_H_HI: h_word[15:8] = b;
                        default:  h_word[7:0]  = b;
                    endcase
                    position = p + 3'd1;
                end
            endcase
        endfunction

        function void report(input string field, input int exp_v, input int act_v);
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_v, act_v);
            errors++;
        endfunction

        // one accepted output word against the oldest owed reading
        function void check_reading(input t_reading got);
            t_reading exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected reading: expected none, got temp %0d humid %0d",
                         $time, got.temperature_centi, got.humidity_centi);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.temperature_centi !== exp_r.temperature_centi)
                report("temperature_centi", int'(exp_r.temperature_centi),
                       int'(got.temperature_centi));
            if (got.humidity_centi !== exp_r.humidity_centi)
                report("humidity_centi", int'(exp_r.humidity_centi), int'(got.humidity_centi));
            if (got.temp_crc_ok !== exp_r.temp_crc_ok)
                report("temp_crc_ok", int'(exp_r.temp_crc_ok), int'(got.temp_crc_ok));
            if (got.humid_crc_ok !== exp_r.humid_crc_ok)
                report("humid_crc_ok", int'(exp_r.humid_crc_ok), int'(got.humid_crc_ok));
            if (got.reading_valid !== exp_r.reading_valid)
                report("reading_valid", int'(exp_r.reading_valid), int'(got.reading_valid));
        endfunction
    endclass

endpackage

### tb/humidity_temp_frame_decoder_tb.sv
module humidity_temp_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import htfd_pkg::*;
    import htfd_tb_pkg::*;

    localparam int                 CYCLE_LIMIT  = 200000;
    localparam int                 DRAIN_CYCLES = 8;
    localparam int                 PHASE_ITEMS  = 115;
    localparam logic [PADDR_W-1:0] OFFSET_ADDR  = PADDR_W'(4 * int'(REG_TEMP_OFFSET));

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    bit                 calm;
    int                 cycle_count = 0;
    reading_scoreboard  sb = new();

    htfd_in_if  in_ch();
    htfd_out_if out_ch();

    humidity_temp_frame_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stalls at random, except in the calm phase
    always @(posedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 34);
    end

    // output monitor and watchdog
    always @(posedge i_clk) begin : monitor
        t_reading got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.temperature_centi = out_ch.temperature_centi;
            got.humidity_centi    = out_ch.humidity_centi;
            got.temp_crc_ok       = out_ch.temp_crc_ok;
            got.humid_crc_ok      = out_ch.humid_crc_ok;
            got.reading_valid     = out_ch.reading_valid;
            sb.check_reading(got);
        end
    end

    // one input word, with a random gap ahead of it except in the calm phase
    task automatic send_byte(input logic [7:0] b, input logic fs);
        while (!calm && $urandom_range(99) < 34) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.rx_byte     <= b;
        in_ch.frame_start <= fs;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.take_byte(b, fs);
    endtask

    // full six-byte reply; a bad CRC is the good one with some bits flipped
    task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw, input logic fs,
                              input logic t_good, input logic h_good);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = crc8_step(crc8_step(CRC_INIT, tw[15:8]), tw[7:0]);
        h_crc = crc8_step(crc8_step(CRC_INIT, hw[15:8]), hw[7:0]);
        if (!t_good) t_crc ^= 8'($urandom_range(1, 255));
        if (!h_good) h_crc ^= 8'($urandom_range(1, 255));
        send_byte(tw[15:8], fs);
        send_byte(tw[7:0], 1'b0);
        send_byte(t_crc, 1'b0);
        send_byte(hw[15:8], 1'b0);
        send_byte(hw[7:0], 1'b0);
        send_byte(h_crc, 1'b0);
    endtask

    function automatic logic [15:0] word_pick();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly well-formed replies, some stray or broken bursts
    task automatic run_random(input int n_items);
        int sent;
        int k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                send_frame(word_pick(), word_pick(), $urandom_range(99) < 70,
                           $urandom_range(99) < 80, $urandom_range(99) < 80);
                sent += 6;
            end else begin
                k = $urandom_range(1, 5);
                repeat (k) send_byte(8'($urandom_range(255)), $urandom_range(99) < 30);
                sent += k;
            end
        end
    endtask

    // stop sending, wait for owed readings and for the pipeline to settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup then access
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_offset(data[11:0]);
    endtask

    initial begin : stimulus
        int offsets[6];
        offsets = '{2047, -2048, 2000, -2000, 0, 0};
        offsets[4] = $urandom_range(0, 4095) - 2048;

        calm              = 1'b0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.rx_byte     <= '0;
        in_ch.frame_start <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, CRC failures, stray byte, resync
        send_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
        send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1);
        send_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_frame(16'h1234, 16'hFFFF, 1'b1, 1'b1, 1'b0);
        drain();

        // random phases, one offset each; phase 2 runs without idling
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(OFFSET_ADDR, 32'(offsets[ph]));
            calm = (ph == 2);
            run_random(PHASE_ITEMS);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### humidity_temp_frame_decoder.f
rtl/core/htfd_pkg.sv
rtl/core/htfd_in_if.sv
rtl/core/htfd_out_if.sv
rtl/core/htfd_framer.sv
rtl/core/humidity_temp_frame_decoder.sv
tb/htfd_tb_pkg.sv
tb/humidity_temp_frame_decoder_tb.sv
